@@ rtl/tkf_pkg.sv @@
// shared types, constants and tables for the tilt kalman fusion block
package tkf_pkg;

   localparam int CAL_SAMPLES_DEF = 2000;
   localparam int CORDIC_ITER_DEF = 24;

   localparam logic [15:0] STEP_TIME_RST  = 16'd655;
   localparam logic [31:0] PROC_NOISE_RST = 32'd429497;
   localparam logic [31:0] MEAS_NOISE_RST = 32'd2415919104;
   localparam logic [31:0] VAR_RST        = 32'h4000_0000;

   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 29;
   localparam int MUL_P_W = 63;
   localparam int DIV_Q_W = 29;
   localparam int DIV_D_W = 33;

   localparam int CSR_IDX_W = 2;
   localparam int ATAN_W    = 30;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_TIME  = 2'd0,
      CSR_PROC_NOISE = 2'd1,
      CSR_MEAS_NOISE = 2'd2
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQB,
      ST_SQC,
      ST_TILT,
      ST_RATE,
      ST_RDIV,
      ST_PMUL,
      ST_KDIV,
      ST_CMUL,
      ST_VMUL,
      ST_DONE
   } state_type;

   // atan(2^-i) in degrees scaled by 2^24
   localparam logic [ATAN_W-1:0] ATAN_DEG [32] = '{
      30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
      30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
      30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
      30'd234684,    30'd117342,    30'd58671,     30'd29335,
      30'd14668,     30'd7334,      30'd3667,      30'd1833,
      30'd917,       30'd458,       30'd229,       30'd115,
      30'd57,        30'd29,        30'd14,        30'd7,
      30'd4,         30'd2,         30'd1,         30'd0
   };

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -36'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/tilt_kalman_fusion.sv @@
// top level: calibration, sequencer and kalman state for roll and pitch
//
//   channel  handshake          payload
//   req      req_valid/stall    gyro rates, accel x/y/z
//   rsp      rsp_valid/stall    roll/pitch estimate and variance
//   csr      csr_valid/ready    csr_index, csr_data
//
// the first CAL_SAMPLES requests are taken without a stall and give no result
// after that each request runs roll then pitch through the shared bit-serial multiplier
// and divider and the tilt unit; the gain divide is skipped on a zero divisor
// synchronous reset loads the default registers and restarts calibration
// req_stall is high while a request is in work; a stalled result holds the next one in done
module tilt_kalman_fusion #(
   parameter int CAL_SAMPLES       = tkf_pkg::CAL_SAMPLES_DEF,
   parameter int CORDIC_ITERATIONS = tkf_pkg::CORDIC_ITER_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [15:0]               req_gyro_roll_rate,
   input  logic signed [15:0]               req_gyro_pitch_rate,
   input  logic signed [15:0]               req_accel_x,
   input  logic signed [15:0]               req_accel_y,
   input  logic signed [15:0]               req_accel_z,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [31:0]               rsp_roll_estimate,
   output logic signed [31:0]               rsp_pitch_estimate,
   output logic [31:0]                      rsp_roll_variance,
   output logic [31:0]                      rsp_pitch_variance,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tkf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_data
);
   localparam logic [28:0] K_ONE = 29'h1000_0000;

   tkf_pkg::state_type state_ff, state_in;
   logic               axis_ff, axis_in, pend_ff, pend_in;
   logic [15:0]        step_ff, step_in;
   logic [31:0]        qn_ff, qn_in, rn_ff, rn_in;
   logic signed [15:0] gr_ff, gr_in, gp_ff, gp_in, ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic signed [27:0] rbias_ff, rbias_in, pbias_ff, pbias_in;
   logic [12:0]        cnt_ff, cnt_in;
   logic signed [31:0] rang_ff, rang_in, pang_ff, pang_in;
   logic [31:0]        rvar_ff, rvar_in, pvar_ff, pvar_in;
   logic [31:0]        sumsq_ff, sumsq_in;
   logic signed [24:0] meas_ff, meas_in;
   logic signed [29:0] diff_ff, diff_in, rate_ff, rate_in;
   logic signed [31:0] pred_ff, pred_in;
   logic [31:0]        p_ff, p_in;
   logic [32:0]        den_ff, den_in;
   logic [28:0]        k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] out_rang_ff, out_rang_in, out_pang_ff, out_pang_in;
   logic [31:0]        out_rvar_ff, out_rvar_in, out_pvar_ff, out_pvar_in;

   logic                                 mul_start, mul_done;
   logic signed [tkf_pkg::MUL_A_W-1:0]   mul_a;
   logic [tkf_pkg::MUL_B_W-1:0]          mul_b;
   logic signed [tkf_pkg::MUL_P_W-1:0]   mul_prod;
   logic                                 div_start, div_done;
   logic [tkf_pkg::DIV_D_W-1:0]          div_hi, div_den;
   logic [tkf_pkg::DIV_Q_W-1:0]          div_lo, div_quot;
   logic                                 tilt_start, tilt_done;
   logic signed [23:0]                   tilt_angle;

   logic signed [15:0] sel_a, sel_b, sel_raw;
   logic signed [27:0] sel_bias;
   logic signed [31:0] sel_ang;
   logic [31:0]        sel_var;
   logic signed [16:0] ext_b, ext_c;
   logic [16:0]        abs_b, abs_c;
   logic signed [29:0] raw_x, cal_x, q30;
   logic [29:0]        abs_diff;
   logic [40:0]        shifted;
   logic [32:0]        p_sum;
   logic [31:0]        p_sat;
   logic signed [24:0] m25;
   logic [62:0]        rsum;
   logic signed [35:0] tot;
   logic               accept, out_free;

   tkf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   tkf_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_hi (div_hi),
      .num_lo (div_lo),
      .den    (div_den),
      .done   (div_done),
      .quot   (div_quot)
   );

   tkf_tilt #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_tilt (
      .clock (clock),
      .reset (reset),
      .start (tilt_start),
      .sumsq (sumsq_ff),
      .num   (sel_a),
      .done  (tilt_done),
      .angle (tilt_angle)
   );

   assign req_stall = (state_ff != tkf_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      sel_a    = axis_ff ? ax_ff : ay_ff;
      sel_b    = axis_ff ? ay_ff : ax_ff;
      sel_raw  = axis_ff ? gp_ff : gr_ff;
      sel_bias = axis_ff ? pbias_ff : rbias_ff;
      sel_ang  = axis_ff ? pang_ff : rang_ff;
      sel_var  = axis_ff ? pvar_ff : rvar_ff;
      ext_b    = {sel_b[15], sel_b};
      ext_c    = {az_ff[15], az_ff};
      abs_b    = ext_b[16] ? -ext_b : ext_b;
      abs_c    = ext_c[16] ? -ext_c : ext_c;
      raw_x    = {{14{sel_raw[15]}}, sel_raw};
      cal_x    = 30'(CAL_SAMPLES);
      abs_diff = diff_ff[29] ? -diff_ff : diff_ff;
      shifted  = {abs_diff[28:0], 12'h000};
      p_sum    = {1'b0, sel_var} + {1'b0, qn_ff};
      p_sat    = p_sum[32] ? '1 : p_sum[31:0];
      q30      = {1'b0, div_quot};
      m25      = {tilt_angle[23], tilt_angle};
      rsum     = '0;
      tot      = '0;

      state_in     = state_ff;
      axis_in      = axis_ff;
      pend_in      = pend_ff;
      step_in      = step_ff;
      qn_in        = qn_ff;
      rn_in        = rn_ff;
      gr_in        = gr_ff;
      gp_in        = gp_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      rbias_in     = rbias_ff;
      pbias_in     = pbias_ff;
      cnt_in       = cnt_ff;
      rang_in      = rang_ff;
      pang_in      = pang_ff;
      rvar_in      = rvar_ff;
      pvar_in      = pvar_ff;
      sumsq_in     = sumsq_ff;
      meas_in      = meas_ff;
      diff_in      = diff_ff;
      rate_in      = rate_ff;
      pred_in      = pred_ff;
      p_in         = p_ff;
      den_in       = den_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_rang_in  = out_rang_ff;
      out_pang_in  = out_pang_ff;
      out_rvar_in  = out_rvar_ff;
      out_pvar_in  = out_pvar_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_hi       = '0;
      div_lo       = '0;
      div_den      = '0;
      tilt_start   = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            tkf_pkg::CSR_STEP_TIME:  step_in = csr_data[15:0];
            tkf_pkg::CSR_PROC_NOISE: qn_in   = csr_data;
            tkf_pkg::CSR_MEAS_NOISE: rn_in   = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         tkf_pkg::ST_IDLE: begin
            if (accept) begin
               if (cnt_ff != 13'(CAL_SAMPLES)) begin
                  rbias_in = rbias_ff + {{12{req_gyro_roll_rate[15]}}, req_gyro_roll_rate};
                  pbias_in = pbias_ff + {{12{req_gyro_pitch_rate[15]}}, req_gyro_pitch_rate};
                  cnt_in   = cnt_ff + 1'b1;
               end else begin
                  gr_in    = req_gyro_roll_rate;
                  gp_in    = req_gyro_pitch_rate;
                  ax_in    = req_accel_x;
                  ay_in    = req_accel_y;
                  az_in    = req_accel_z;
                  axis_in  = 1'b0;
                  pend_in  = 1'b0;
                  state_in = tkf_pkg::ST_SQB;
               end
            end
         end
         tkf_pkg::ST_SQB: begin
            mul_a = {17'h00000, abs_b};
            mul_b = {12'h000, abs_b};
            if (!pend_ff) begin
               mul_start = 1'b1;
               pend_in   = 1'b1;
            end else if (mul_done) begin
               sumsq_in = mul_prod[31:0];
               pend_in  = 1'b0;
               state_in = tkf_pkg::ST_SQC;
            end
         end
         tkf_pkg::ST_SQC: begin
            mul_a = {17'h00000, abs_c};
            mul_b = {12'h000, abs_c};
            if (!pend_ff) begin
               mul_start = 1'b1;
               pend_in   = 1'b1;
            end else if (mul_done) begin
               sumsq_in = sumsq_ff + mul_prod[31:0];
               pend_in  = 1'b0;
               state_in = tkf_pkg::ST_TILT;
            end
         end
         tkf_pkg::ST_TILT: begin
            if (!pend_ff) begin
               tilt_start = 1'b1;
               pend_in    = 1'b1;
            end else if (tilt_done) begin
               meas_in  = axis_ff ? -m25 : m25;
               pend_in  = 1'b0;
               state_in = tkf_pkg::ST_RATE;
            end
         end
         tkf_pkg::ST_RATE: begin
            diff_in  = raw_x * cal_x - {{2{sel_bias[27]}}, sel_bias};
            p_in     = p_sat;
            den_in   = {1'b0, p_sat} + {1'b0, rn_ff};
            state_in = tkf_pkg::ST_RDIV;
         end
         tkf_pkg::ST_RDIV: begin
            div_hi  = {21'h000000, shifted[40:29]};
            div_lo  = shifted[28:0];
            div_den = tkf_pkg::DIV_D_W'(CAL_SAMPLES);
            if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end else if (div_done) begin
               rate_in  = diff_ff[29] ? -q30 : q30;
               pend_in  = 1'b0;
               state_in = tkf_pkg::ST_PMUL;
            end
         end
         tkf_pkg::ST_PMUL: begin
            mul_a = {{4{rate_ff[29]}}, rate_ff};
            mul_b = {13'h0000, step_ff};
            if (!pend_ff) begin
               mul_start = 1'b1;
               pend_in   = 1'b1;
            end else if (mul_done) begin
               rsum     = mul_prod + 63'sd32768;
               tot      = {{4{sel_ang[31]}}, sel_ang} + {{2{rsum[49]}}, rsum[49:16]};
               pred_in  = tkf_pkg::sat32(tot);
               pend_in  = 1'b0;
               state_in = tkf_pkg::ST_KDIV;
            end
         end
         tkf_pkg::ST_KDIV: begin
            div_hi  = {2'b00, p_ff[31:1]};
            div_lo  = {p_ff[0], 28'h0000000};
            div_den = den_ff;
            if (!pend_ff) begin
               if (den_ff == '0) begin
                  k_in     = '0;
                  state_in = tkf_pkg::ST_CMUL;
               end else begin
                  div_start = 1'b1;
                  pend_in   = 1'b1;
               end
            end else if (div_done) begin
               k_in     = div_quot;
               pend_in  = 1'b0;
               state_in = tkf_pkg::ST_CMUL;
            end
         end
         tkf_pkg::ST_CMUL: begin
            mul_a = {{9{meas_ff[24]}}, meas_ff} - {{2{pred_ff[31]}}, pred_ff};
            mul_b = k_ff;
            if (!pend_ff) begin
               mul_start = 1'b1;
               pend_in   = 1'b1;
            end else if (mul_done) begin
               rsum = mul_prod + 63'sd134217728;
               tot  = {{4{pred_ff[31]}}, pred_ff} + {rsum[62], rsum[62:28]};
               if (axis_ff) begin
                  pang_in = tkf_pkg::sat32(tot);
               end else begin
                  rang_in = tkf_pkg::sat32(tot);
               end
               pend_in  = 1'b0;
               state_in = tkf_pkg::ST_VMUL;
            end
         end
         tkf_pkg::ST_VMUL: begin
            mul_a = {2'b00, p_ff};
            mul_b = K_ONE - k_ff;
            if (!pend_ff) begin
               mul_start = 1'b1;
               pend_in   = 1'b1;
            end else if (mul_done) begin
               rsum = mul_prod + 63'sd134217728;
               if (axis_ff) begin
                  pvar_in  = rsum[59:28];
                  state_in = tkf_pkg::ST_DONE;
               end else begin
                  rvar_in  = rsum[59:28];
                  axis_in  = 1'b1;
                  state_in = tkf_pkg::ST_SQB;
               end
               pend_in = 1'b0;
            end
         end
         tkf_pkg::ST_DONE: begin
            if (out_free) begin
               out_rang_in  = rang_ff;
               out_pang_in  = pang_ff;
               out_rvar_in  = rvar_ff;
               out_pvar_in  = pvar_ff;
               rsp_valid_in = 1'b1;
               state_in     = tkf_pkg::ST_IDLE;
            end
         end
         default: state_in = tkf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tkf_pkg::ST_IDLE;
         axis_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         step_ff      <= tkf_pkg::STEP_TIME_RST;
         qn_ff        <= tkf_pkg::PROC_NOISE_RST;
         rn_ff        <= tkf_pkg::MEAS_NOISE_RST;
         rbias_ff     <= '0;
         pbias_ff     <= '0;
         cnt_ff       <= '0;
         rang_ff      <= '0;
         pang_ff      <= '0;
         rvar_ff      <= tkf_pkg::VAR_RST;
         pvar_ff      <= tkf_pkg::VAR_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         pend_ff      <= pend_in;
         step_ff      <= step_in;
         qn_ff        <= qn_in;
         rn_ff        <= rn_in;
         rbias_ff     <= rbias_in;
         pbias_ff     <= pbias_in;
         cnt_ff       <= cnt_in;
         rang_ff      <= rang_in;
         pang_ff      <= pang_in;
         rvar_ff      <= rvar_in;
         pvar_ff      <= pvar_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gr_ff       <= gr_in;
      gp_ff       <= gp_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      sumsq_ff    <= sumsq_in;
      meas_ff     <= meas_in;
      diff_ff     <= diff_in;
      rate_ff     <= rate_in;
      pred_ff     <= pred_in;
      p_ff        <= p_in;
      den_ff      <= den_in;
      k_ff        <= k_in;
      out_rang_ff <= out_rang_in;
      out_pang_ff <= out_pang_in;
      out_rvar_ff <= out_rvar_in;
      out_pvar_ff <= out_pvar_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_roll_estimate  = out_rang_ff;
   assign rsp_pitch_estimate = out_pang_ff;
   assign rsp_roll_variance  = out_rvar_ff;
   assign rsp_pitch_variance = out_pvar_ff;
endmodule

@@ rtl/tkf_mul.sv @@
// bit-serial signed by unsigned shift-add multiplier
module tkf_mul (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [tkf_pkg::MUL_A_W-1:0]      mul_a,
   input  logic        [tkf_pkg::MUL_B_W-1:0]      mul_b,
   output logic                                    done,
   output logic signed [tkf_pkg::MUL_P_W-1:0]      product
);
   localparam int AW = tkf_pkg::MUL_A_W;
   localparam int BW = tkf_pkg::MUL_B_W;
   localparam int CW = $clog2(BW);

   logic signed [AW:0]   hi_ff, hi_in, sum;
   logic [BW-1:0]        lo_ff, lo_in;
   logic signed [AW-1:0] a_ff, a_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [AW+BW:0]       full;

   always_comb begin
      sum     = lo_ff[0] ? hi_ff + {a_ff[AW-1], a_ff} : hi_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = mul_a;
         hi_in   = '0;
         lo_in   = mul_b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum >>> 1;
         lo_in  = {sum[0], lo_ff[BW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      a_ff   <= a_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign full    = {hi_ff, lo_ff};
   assign product = full[tkf_pkg::MUL_P_W-1:0];
   assign done    = done_ff;
endmodule

@@ rtl/tkf_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module tkf_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tkf_pkg::DIV_D_W-1:0]     num_hi,
   input  logic [tkf_pkg::DIV_Q_W-1:0]     num_lo,
   input  logic [tkf_pkg::DIV_D_W-1:0]     den,
   output logic                            done,
   output logic [tkf_pkg::DIV_Q_W-1:0]     quot
);
   localparam int QW = tkf_pkg::DIV_Q_W;
   localparam int DW = tkf_pkg::DIV_D_W;
   localparam int CW = $clog2(QW);

   logic [DW-1:0] r_ff, r_in, d_ff, d_in;
   logic [QW-1:0] q_ff, q_in;
   logic [DW:0]   trial, diff;
   logic          ge;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      trial   = {r_ff, q_ff[QW-1]};
      diff    = trial - {1'b0, d_ff};
      ge      = trial >= {1'b0, d_ff};
      r_in    = r_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         r_in    = num_hi;
         q_in    = num_lo;
         d_in    = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = ge ? diff[DW-1:0] : trial[DW-1:0];
         q_in   = {q_ff[QW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot = q_ff;
   assign done = done_ff;
endmodule

@@ rtl/tkf_tilt.sv @@
// tilt angle unit: serial square root then cordic vectoring
module tkf_tilt #(
   parameter int ITERATIONS = tkf_pkg::CORDIC_ITER_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        sumsq,
   input  logic signed [15:0] num,
   output logic               done,
   output logic signed [23:0] angle
);
   localparam int ROOT_STEPS = 24;

   logic [47:0]        n_ff, n_in;
   logic [25:0]        rem_ff, rem_in;
   logic [23:0]        root_ff, root_in;
   logic [26:0]        t, trial;
   logic               ge;
   logic signed [15:0] a_ff, a_in;
   logic signed [27:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [31:0] z_ff, z_in, at, rnd;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in, cord_ff, cord_in, zero_ff, zero_in;
   logic               done_ff, done_in;

   always_comb begin
      t       = {rem_ff[24:0], n_ff[47:46]};
      trial   = {1'b0, root_ff, 2'b01};
      ge      = t >= trial;
      dx      = x_ff >>> cnt_ff;
      dy      = y_ff >>> cnt_ff;
      at      = {2'b00, tkf_pkg::ATAN_DEG[cnt_ff]};
      n_in    = n_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      a_in    = a_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      cord_in = cord_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = {sumsq, 16'h0000};
         rem_in  = '0;
         root_in = '0;
         a_in    = num;
         cnt_in  = '0;
         busy_in = 1'b1;
         cord_in = 1'b0;
      end else if (busy_ff && !cord_ff) begin
         rem_in  = ge ? 26'(t - trial) : t[25:0];
         root_in = {root_ff[22:0], ge};
         n_in    = {n_ff[45:0], 2'b00};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == 5'(ROOT_STEPS - 1)) begin
            x_in    = {4'b0000, root_in};
            y_in    = {{4{a_ff[15]}}, a_ff, 8'h00};
            z_in    = '0;
            zero_in = (root_in == '0) && (a_ff == '0);
            cnt_in  = '0;
            cord_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!y_ff[27]) begin
            x_in = x_ff + dy;
            y_in = y_ff - dx;
            z_in = z_ff + at;
         end else begin
            x_in = x_ff - dy;
            y_in = y_ff + dx;
            z_in = z_ff - at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 5'(ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      a_ff    <= a_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cnt_ff  <= cnt_in;
      cord_ff <= cord_in;
      zero_ff <= zero_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rnd   = z_ff + 32'sd128;
   assign angle = zero_ff ? '0 : rnd[31:8];
   assign done  = done_ff;
endmodule
